[design/lagi_pkg.sv]
// lagi_pkg: shared types and constants for the lagrange interpolator
// no dependencies; imported by lagrange_interpolator and the testbench
`default_nettype none

package lagi_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_RD,
        S_DUP_CMP,
        S_EV_NEXT,
        S_EV_RD,
        S_DIV_SETUP,
        S_DIV,
        S_FCLAMP,
        S_BMUL,
        S_BCLAMP,
        S_TMUL,
        S_TACC,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

[design/lagrange_interpolator.sv]
// lagrange_interpolator: point store plus sequencer around one shared
// restoring divider and one 32x32 multiplier; depends on lagi_pkg
`default_nettype none

// channel     | ports                                         | handshake
// ------------+-----------------------------------------------+--------------------------
// item in     | i_func i_slot i_x_value i_y_value             | start high, busy low
// result out  | o_value o_duplicate_error o_saturated         | o_valid one-cycle strobe
// config      | i_cfg_wdata (point_count)                     | i_cfg_we, no wait
//
// a load item is written on acceptance; busy stays low
// an evaluate item keeps busy high until its result is registered; its run time is set
// by the bit-serial divider, which runs once for each factor;
// a duplicate abscissa ends the item after the compare pass
// reset is synchronous active low; point slots are undefined until loaded
// the result strobe cannot be stalled by the receiver
module lagrange_interpolator #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire                                   i_func,
    input  wire  [lagi_pkg::SLOT_W-1:0]           i_slot,
    input  wire  signed [lagi_pkg::DATA_W-1:0]    i_x_value,
    input  wire  signed [lagi_pkg::DATA_W-1:0]    i_y_value,
    input  wire                                   i_cfg_we,
    input  wire  [lagi_pkg::COUNT_W-1:0]          i_cfg_wdata,
    output logic                                  o_valid,
    output logic signed [lagi_pkg::DATA_W-1:0]    o_value,
    output logic                                  o_duplicate_error,
    output logic                                  o_saturated
);
    import lagi_pkg::*;

    localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int DW  = 33 + FRAC_BITS;
    localparam int DCW = $clog2(DW + 1);

    localparam logic [63:0] LIM_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM_NEG = 64'h0000_0000_8000_0000;

    // point store
    logic signed [DATA_W-1:0] mem_x [MAX_POINTS];
    logic signed [DATA_W-1:0] mem_y [MAX_POINTS];

    logic                     r_valid, n_valid;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_dupo, n_dupo;
    logic                     r_sato, n_sato;
    logic [COUNT_W-1:0]       r_point_count;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_k, n_k, r_i, n_i, r_n, n_n;
    logic signed [DATA_W-1:0] r_q, n_q;
    logic                     r_dup, n_dup, r_sat, n_sat;
    logic signed [DATA_W-1:0] r_basis, n_basis, r_f, n_f;
    logic [32:0]              r_rem, n_rem, r_dvs, n_dvs;
    logic [DW-1:0]            r_dvd, n_dvd;
    logic                     r_dneg, n_dneg;
    logic [DCW-1:0]           r_cnt, n_cnt;
    logic [63:0]              r_prod, n_prod;
    logic                     r_pneg, n_pneg;
    logic signed [63:0]       r_sum, n_sum;
    logic signed [DATA_W-1:0] r_xk, r_xi, r_yk;

    logic                     w_accept;
    logic [7:0]               w_pc;
    logic [CW-1:0]            w_n;
    logic signed [32:0]       w_num, w_den;
    logic [32:0]              w_num_mag, w_den_mag;
    logic [33:0]              w_rem_sh;
    logic                     w_ge;
    logic [31:0]              w_ma, w_mb;
    logic [63:0]              w_prod, w_m;
    logic signed [63:0]       w_term;
    logic [CW:0]              w_i1, w_k1, w_k2;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_duplicate_error = r_dupo;
    assign o_saturated       = r_sato;

    // effective point count
    always_comb begin
        w_pc = 8'(r_point_count);
        if (w_pc == 8'd0) begin
            w_n = CW'(1);
        end else if (32'(w_pc) > MAX_POINTS) begin
            w_n = CW'(MAX_POINTS);
        end else begin
            w_n = CW'(w_pc);
        end
    end

    // point store write and registered reads
    always_ff @(posedge i_clk) begin
        if (w_accept && i_func == FUNC_LOAD && 32'(i_slot) < MAX_POINTS) begin
            mem_x[IW'(i_slot)] <= i_x_value;
            mem_y[IW'(i_slot)] <= i_y_value;
        end
        r_xk <= mem_x[r_k[IW-1:0]];
        r_xi <= mem_x[r_i[IW-1:0]];
        r_yk <= mem_y[r_k[IW-1:0]];
    end

    // divider datapath: differences, magnitudes and one restoring step
    always_comb begin
        w_num     = 33'(r_q) - 33'(r_xi);
        w_den     = 33'(r_xk) - 33'(r_xi);
        w_num_mag = w_num[32] ? 33'(-w_num) : 33'(w_num);
        w_den_mag = w_den[32] ? 33'(-w_den) : 33'(w_den);
        w_rem_sh  = {r_rem, r_dvd[DW-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_dvs});
    end

    // shared multiplier on magnitudes
    always_comb begin
        if (r_state == S_BMUL) begin
            w_ma = r_basis[31] ? 32'(-r_basis) : 32'(r_basis);
            w_mb = r_f[31] ? 32'(-r_f) : 32'(r_f);
        end else begin
            w_ma = r_yk[31] ? 32'(-r_yk) : 32'(r_yk);
            w_mb = r_basis[31] ? 32'(-r_basis) : 32'(r_basis);
        end
        w_prod = 64'(w_ma) * 64'(w_mb);
        w_m    = r_prod >> FRAC_BITS;
        w_term = r_pneg ? -$signed(w_m) : $signed(w_m);
        w_i1   = (CW+1)'(r_i) + 1'b1;
        w_k1   = (CW+1)'(r_k) + 1'b1;
        w_k2   = (CW+1)'(r_k) + 2'd2;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_k = r_k;   n_i = r_i;   n_n = r_n;   n_q = r_q;
        n_dup = r_dup;  n_sat = r_sat;
        n_basis = r_basis;  n_f = r_f;
        n_rem = r_rem;  n_dvs = r_dvs;  n_dvd = r_dvd;  n_dneg = r_dneg;
        n_cnt = r_cnt;  n_prod = r_prod;  n_pneg = r_pneg;  n_sum = r_sum;
        n_valid = 1'b0;
        n_value = r_value;  n_dupo = r_dupo;  n_sato = r_sato;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_func == FUNC_EVAL) begin
                    n_q     = i_x_value;
                    n_n     = w_n;
                    n_k     = '0;
                    n_dup   = 1'b0;
                    n_sat   = 1'b0;
                    n_sum   = '0;
                    n_basis = DATA_W'(64'd1 << FRAC_BITS);
                    if (w_n == CW'(1)) begin
                        n_i     = '0;
                        n_state = S_EV_NEXT;
                    end else begin
                        n_i     = CW'(1);
                        n_state = S_DUP_RD;
                    end
                end
            end
            S_DUP_RD: n_state = S_DUP_CMP;
            S_DUP_CMP: begin
                // pairwise abscissa compare, k < i
                n_state = S_DUP_RD;
                if (r_xk == r_xi) n_dup = 1'b1;
                if (w_i1 < (CW+1)'(r_n)) begin
                    n_i = CW'(w_i1);
                end else if (w_k2 < (CW+1)'(r_n)) begin
                    n_k = CW'(w_k1);
                    n_i = CW'(w_k2);
                end else begin
                    n_k = '0;
                    n_i = '0;
                    if (r_dup || r_xk == r_xi) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_EV_NEXT;
                    end
                end
            end
            S_EV_NEXT: begin
                if (r_i >= r_n) begin
                    n_state = S_TMUL;
                end else if (r_i == r_k) begin
                    n_i = CW'(w_i1);
                end else begin
                    n_state = S_EV_RD;
                end
            end
            S_EV_RD: n_state = S_DIV_SETUP;
            S_DIV_SETUP: begin
                n_dvd   = {w_num_mag, FRAC_BITS'(0)};
                n_dvs   = w_den_mag;
                n_dneg  = w_num[32] ^ w_den[32];
                n_rem   = '0;
                n_cnt   = DCW'(DW);
                n_state = S_DIV;
            end
            S_DIV: begin
                // one quotient bit per cycle, quotient shifts into the dividend
                n_rem = w_ge ? 33'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[32:0];
                n_dvd = {r_dvd[DW-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == DCW'(1)) n_state = S_FCLAMP;
            end
            S_FCLAMP: begin
                if (r_dvd > DW'(LIM_NEG) || (r_dvd == DW'(LIM_NEG) && !r_dneg)) begin
                    n_sat = 1'b1;
                end
                if (r_dvd >= DW'(LIM_NEG)) begin
                    n_f = r_dneg ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
                end else begin
                    n_f = r_dneg ? -$signed(32'(r_dvd)) : $signed(32'(r_dvd));
                end
                n_state = S_BMUL;
            end
            S_BMUL: begin
                n_prod  = w_prod;
                n_pneg  = r_basis[31] ^ r_f[31];
                n_state = S_BCLAMP;
            end
            S_BCLAMP: begin
                if (r_pneg) begin
                    if (w_m > LIM_NEG) begin
                        n_sat   = 1'b1;
                        n_basis = $signed(32'h8000_0000);
                    end else begin
                        n_basis = -$signed(32'(w_m));
                    end
                end else begin
                    if (w_m > LIM_POS) begin
                        n_sat   = 1'b1;
                        n_basis = $signed(32'h7FFF_FFFF);
                    end else begin
                        n_basis = $signed(32'(w_m));
                    end
                end
                n_i     = CW'(w_i1);
                n_state = S_EV_NEXT;
            end
            S_TMUL: begin
                n_prod  = w_prod;
                n_pneg  = r_yk[31] ^ r_basis[31];
                n_state = S_TACC;
            end
            S_TACC: begin
                n_sum = r_sum + w_term;
                if (w_k1 < (CW+1)'(r_n)) begin
                    n_k     = CW'(w_k1);
                    n_i     = '0;
                    n_basis = DATA_W'(64'd1 << FRAC_BITS);
                    n_state = S_EV_NEXT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // final clamp and result strobe
                n_valid = 1'b1;
                n_dupo  = r_dup;
                if (r_dup) begin
                    n_value = '0;
                    n_sato  = 1'b0;
                end else if (r_sum > $signed(LIM_POS)) begin
                    n_value = $signed(32'h7FFF_FFFF);
                    n_sato  = 1'b1;
                end else if (r_sum < -$signed(LIM_NEG)) begin
                    n_value = $signed(32'h8000_0000);
                    n_sato  = 1'b1;
                end else begin
                    n_value = $signed(32'(r_sum));
                    n_sato  = r_sat;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= 1'b0;
            r_point_count <= COUNT_W'(1);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) r_point_count <= i_cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_k <= n_k;  r_i <= n_i;  r_n <= n_n;  r_q <= n_q;
        r_dup <= n_dup;  r_sat <= n_sat;
        r_basis <= n_basis;  r_f <= n_f;
        r_rem <= n_rem;  r_dvs <= n_dvs;  r_dvd <= n_dvd;  r_dneg <= n_dneg;
        r_cnt <= n_cnt;  r_prod <= n_prod;  r_pneg <= n_pneg;  r_sum <= n_sum;
        r_value <= n_value;  r_dupo <= n_dupo;  r_sato <= n_sato;
    end

endmodule

`default_nettype wire

[sim/lagrange_interpolator_test.sv]
// lagrange_interpolator_test: self-checking testbench for the lagrange interpolator
// depends on lagi_pkg and lagrange_interpolator; holds its own fixed-point predictor
`default_nettype none

// tracks point store and count, predicts each evaluate result and checks it
class interp_tracker;
    typedef struct {
        logic signed [31:0] value;
        logic               dup;
        logic               sat;
    } interp_result_t;

    logic signed [31:0] abscissa [16];
    logic signed [31:0] ordinate [16];
    logic [lagi_pkg::COUNT_W-1:0] point_count;
    interp_result_t pending_values[$];
    int mismatches;
    int results_seen;
    int evals_seen;
    int dups_seen;
    int sats_seen;

    function new();
        point_count = 1;
        mismatches = 0;
        results_seen = 0;
        evals_seen = 0;
        dups_seen = 0;
        sats_seen = 0;
        for (int i = 0; i < 16; i++) begin
            abscissa[i] = 0;
            ordinate[i] = 0;
        end
    endfunction

    function void set_count(logic [lagi_pkg::COUNT_W-1:0] c);
        point_count = c;
    endfunction

    function longint unsigned mag(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function longint clamp32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function longint mul_q(longint a, longint b);
        longint unsigned m;
        m = (mag(a) * mag(b)) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint div_q(longint num, longint den, inout bit sat);
        longint unsigned m;
        m = (mag(num) << 16) / mag(den);
        if (m > 64'h80000000) m = 64'h80000001;
        return clamp32(((num < 0) != (den < 0)) ? -longint'(m) : longint'(m), sat);
    endfunction

    // lagrange sum over the first n points at query q
    function interp_result_t eval_poly(longint q);
        interp_result_t r;
        int n;
        bit sat;
        bit dup;
        longint sum;
        longint basis;
        longint f;
        n = point_count;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        sat = 0;
        dup = 0;
        sum = 0;
        for (int k = 0; k < n; k++)
            for (int i = k + 1; i < n; i++)
                if (abscissa[k] == abscissa[i]) dup = 1;
        if (!dup) begin
            for (int k = 0; k < n; k++) begin
                basis = 64'sd65536;
                for (int i = 0; i < n; i++) begin
                    if (i == k) continue;
                    f = div_q(q - longint'(abscissa[i]),
                              longint'(abscissa[k]) - longint'(abscissa[i]), sat);
                    basis = clamp32(mul_q(basis, f), sat);
                end
                sum += mul_q(longint'(ordinate[k]), basis);
            end
            sum = clamp32(sum, sat);
        end else begin
            sat = 0;
            sum = 0;
        end
        r.value = sum[31:0];
        r.dup = dup;
        r.sat = sat;
        return r;
    endfunction

    // accepted item: store a point or queue the predicted value
    function void note_item(logic func, logic [3:0] slot, logic signed [31:0] x,
                            logic signed [31:0] y);
        if (func == lagi_pkg::FUNC_LOAD) begin
            abscissa[slot] = x;
            ordinate[slot] = y;
        end else begin
            pending_values.push_back(eval_poly(longint'(x)));
            evals_seen++;
        end
    endfunction

    function void check_result(logic signed [31:0] value, logic dup, logic sat);
        interp_result_t e;
        results_seen++;
        if (dup) dups_seen++;
        if (sat) sats_seen++;
        if (pending_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result value=%h dup=%b sat=%b", value, dup, sat);
            return;
        end
        e = pending_values.pop_front();
        if (value !== e.value || dup !== e.dup || sat !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp value=%h dup=%b sat=%b got value=%h dup=%b sat=%b",
                         e.value, e.dup, e.sat, value, dup, sat);
        end
    endfunction
endclass

module lagrange_interpolator_test;
    import lagi_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_func;
    logic [SLOT_W-1:0]           i_slot;
    logic signed [DATA_W-1:0]    i_x_value;
    logic signed [DATA_W-1:0]    i_y_value;
    logic                        i_cfg_we;
    logic [COUNT_W-1:0]          i_cfg_wdata;
    logic                        o_valid;
    logic signed [DATA_W-1:0]    o_value;
    logic                        o_duplicate_error;
    logic                        o_saturated;

    interp_tracker tracker;
    int  cycles;
    bit  gaps_on;
    int  cfg_writes;

    lagrange_interpolator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_slot(i_slot), .i_x_value(i_x_value),
        .i_y_value(i_y_value), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_value(o_value),
        .o_duplicate_error(o_duplicate_error), .o_saturated(o_saturated)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            tracker.check_result(o_value, o_duplicate_error, o_saturated);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // drive one item and wait until it is taken
    task automatic push_item(logic func, logic [3:0] slot, logic signed [31:0] x,
                             logic signed [31:0] y);
        start     <= 1;
        i_func    <= func;
        i_slot    <= slot;
        i_x_value <= x;
        i_y_value <= y;
        do @(posedge i_clk); while (busy);
        tracker.note_item(func, slot, x, y);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // write point_count once the block has drained
    task automatic set_point_count(logic [COUNT_W-1:0] c);
        start <= 0;
        while (tracker.pending_values.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 0;
        tracker.set_count(c);
        cfg_writes++;
    endtask

    // mostly small abscissas with a random fraction, sometimes any 32-bit value
    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return ($urandom_range(0, 16) - 8) * 65536 + $urandom_range(0, 65535);
    endfunction

    initial begin
        logic [COUNT_W-1:0] c;
        tracker = new();
        cycles = 0;
        cfg_writes = 0;
        gaps_on = 1;
        i_rst_n = 0;
        start = 0;
        i_func = 0;
        i_slot = 0;
        i_x_value = 0;
        i_y_value = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: fill every slot with distinct abscissas, extremes of y
        for (int s = 0; s < 16; s++)
            push_item(FUNC_LOAD, s[3:0], (s - 8) * 65536,
                      s == 0 ? 32'sh7fffffff : s == 1 ? 32'sh80000000 : s * 12345);
        // reset count of one, extreme queries
        push_item(FUNC_EVAL, 4'd0, 32'sh7fffffff, 0);
        push_item(FUNC_EVAL, 4'd0, 32'sh80000000, 32'shffffffff);
        set_point_count(5'd0);
        push_item(FUNC_EVAL, 4'd0, 0, 0);
        set_point_count(5'd3);
        push_item(FUNC_EVAL, 4'd0, 32'sh7fffffff, 0);
        push_item(FUNC_EVAL, 4'd0, 32'sh00018000, 0);
        // duplicate abscissa among used points
        push_item(FUNC_LOAD, 4'd2, -8 * 65536, 32'sh12345678);
        push_item(FUNC_EVAL, 4'd0, 0, 0);
        push_item(FUNC_LOAD, 4'd2, 32'sh80000000, 32'sh7fffffff);
        push_item(FUNC_EVAL, 4'd0, 32'sh7fffffff, 0);
        // count above the store size and at its top
        set_point_count(5'd31);
        push_item(FUNC_EVAL, 4'd0, 32'sh00004000, 0);
        set_point_count(5'd16);
        push_item(FUNC_EVAL, 4'd0, 32'sh7fffffff, 0);

        // random phases with small counts and an occasional count from the whole 5-bit range
        for (int item = 0; item < 72; item++) begin
            if (item % 18 == 0) begin
                c = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 5));
                set_point_count(c);
            end
            gaps_on = item < 56;
            if ($urandom_range(0, 1) == 0)
                push_item(FUNC_LOAD, ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                                 : 4'($urandom_range(0, 4)),
                          rand_coord(), ($urandom_range(0, 2) == 0) ? $urandom
                                                                    : rand_coord());
            else
                push_item(FUNC_EVAL, 4'($urandom), rand_coord(), $urandom);
        end

        start <= 0;
        while (tracker.pending_values.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d evaluations, %0d results, %0d duplicate, %0d saturated",
                 tracker.evals_seen, tracker.results_seen, tracker.dups_seen,
                 tracker.sats_seen);
        $display("point_count written %0d times, %0d mismatches", cfg_writes,
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_values.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire

[lagrange_interpolator.f]
design/lagi_pkg.sv
design/lagrange_interpolator.sv
sim/lagrange_interpolator_test.sv
